>>> rtl/core/ttuv_pkg.sv
package ttuv_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_SUB,
    ST_PREP,
    ST_NORM,
    ST_SQ,
    ST_SQRT,
    ST_DIV,
    ST_DIVW,
    ST_OUT
  } state_t;

  localparam int unsigned POS_W     = 32;
  localparam int unsigned TEX_W     = 20;
  localparam int unsigned TAN_W     = 16;
  localparam int unsigned EDGE_W    = POS_W + 1;
  localparam int unsigned DTEX_W    = TEX_W + 1;
  localparam int unsigned PROD_W    = EDGE_W + DTEX_W;
  localparam int unsigned RAW_W     = PROD_W + 1;
  localparam int unsigned DET_W     = 2 * DTEX_W + 1;
  localparam int unsigned NRM_W     = 30;
  localparam int unsigned SQ_W      = 2 * NRM_W;
  localparam int unsigned SUM_W     = SQ_W + 2;
  localparam int unsigned ROOT_W    = 63;
  localparam int unsigned RDIV_W    = 31;
  localparam int unsigned SQRT_STEPS = 32;
  localparam int unsigned DIV_STEPS  = 16;
  localparam int unsigned CNT_W     = 6;

  localparam logic [1:0] PHASE_LAST = 2'd2;
  localparam logic [1:0] LAST_BEAT  = 2'd2;
  localparam logic [1:0] SLOT_DET   = 2'd3;
  localparam logic [1:0] SLOT_Z     = 2'd2;

  typedef struct packed {
    logic       hold_wr;
    logic       hold_sel;
    logic       capture;
    logic       mul;
    logic       sub;
    logic [1:0] idx;
    logic       prep;
    logic       norm;
    logic       sq;
    logic       sqrt_init;
    logic       sqrt_step;
    logic       div_init;
    logic       div_step;
    logic       div_store;
  } cmd_t;

  typedef struct packed {
    logic degen;
    logic norm_ok;
  } sts_t;

endpackage

>>> rtl/core/triangle_tangent_from_uv.sv
// Takes a triangle list one vertex per input beat and returns, for every third vertex, three
// result beats carrying the same unit tangent in Q1.15, the last one marked. The first two
// vertices of a triangle are taken in one cycle each, and may be taken while the previous
// triangle's results are still waiting. The third vertex starts the triangle's computation:
// shared multipliers for the edge products and determinant, a preparation step, normalizing
// steps, squaring, a one-bit-per-cycle square root and three divisions including their store
// step. The third vertex of the next triangle is not taken until all three result beats of
// this one are gone. A degenerate triangle skips the normalization, square root and divisions
// and goes from the normalizing state straight to its result beats.
module triangle_tangent_from_uv (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [ttuv_pkg::POS_W-1:0]   in_pos_x,
  input  logic signed [ttuv_pkg::POS_W-1:0]   in_pos_y,
  input  logic signed [ttuv_pkg::POS_W-1:0]   in_pos_z,
  input  logic signed [ttuv_pkg::TEX_W-1:0]   in_tex_u,
  input  logic signed [ttuv_pkg::TEX_W-1:0]   in_tex_v,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [ttuv_pkg::TAN_W-1:0]   out_tangent_x,
  output logic signed [ttuv_pkg::TAN_W-1:0]   out_tangent_y,
  output logic signed [ttuv_pkg::TAN_W-1:0]   out_tangent_z,
  output logic                                out_degenerate,
  output logic                                out_last_of_triangle
);
  import ttuv_pkg::*;

  cmd_t cmd;
  sts_t sts;

  ttuv_ctrl u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .last_of_triangle (out_last_of_triangle),
    .cmd              (cmd),
    .sts              (sts)
  );

  ttuv_dp u_dp (
    .clk        (clk),
    .in_pos_x   (in_pos_x),
    .in_pos_y   (in_pos_y),
    .in_pos_z   (in_pos_z),
    .in_tex_u   (in_tex_u),
    .in_tex_v   (in_tex_v),
    .cmd        (cmd),
    .sts        (sts),
    .tangent_x  (out_tangent_x),
    .tangent_y  (out_tangent_y),
    .tangent_z  (out_tangent_z),
    .degenerate (out_degenerate)
  );

endmodule

>>> rtl/core/ttuv_ctrl.sv
module ttuv_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output logic          last_of_triangle,
  output ttuv_pkg::cmd_t cmd,
  input  ttuv_pkg::sts_t sts
);
  import ttuv_pkg::*;

  state_t             state_r, state_nxt;
  logic [1:0]         phase_r, phase_nxt;
  logic [1:0]         idx_r, idx_nxt;
  logic [1:0]         beat_r, beat_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      phase_r <= '0;
      idx_r   <= '0;
      beat_r  <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      idx_r   <= idx_nxt;
      beat_r  <= beat_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    idx_nxt   = idx_r;
    beat_nxt  = beat_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    cmd.idx   = idx_r;
    out_valid = 1'b0;
    in_ready  = (state_r == ST_IDLE) || ((state_r == ST_OUT) && !phase_r[1]);
    accept    = in_valid && in_ready;

    if (accept) begin
      if (!phase_r[1]) begin
        cmd.hold_wr  = 1'b1;
        cmd.hold_sel = phase_r[0];
        phase_nxt    = phase_r + 2'd1;
      end else begin
        cmd.capture = 1'b1;
        phase_nxt   = '0;
        idx_nxt     = '0;
        state_nxt   = ST_MUL;
      end
    end

    case (state_r)
      ST_IDLE: begin
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_SUB;
      end
      ST_SUB: begin
        cmd.sub = 1'b1;
        if (idx_r == SLOT_DET) begin
          state_nxt = ST_PREP;
        end else begin
          idx_nxt   = idx_r + 2'd1;
          state_nxt = ST_MUL;
        end
      end
      ST_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = ST_NORM;
      end
      ST_NORM: begin
        if (sts.degen) begin
          beat_nxt  = '0;
          state_nxt = ST_OUT;
        end else if (sts.norm_ok) begin
          cnt_nxt   = '0;
          state_nxt = ST_SQ;
        end else begin
          cmd.norm = 1'b1;
        end
      end
      ST_SQ: begin
        cmd.sq  = 1'b1;
        cmd.idx = cnt_r[1:0];
        if (cnt_r[1:0] == SLOT_DET) begin
          cnt_nxt   = '0;
          state_nxt = ST_SQRT;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      ST_SQRT: begin
        if (cnt_r == '0) begin
          cmd.sqrt_init = 1'b1;
        end else begin
          cmd.sqrt_step = 1'b1;
        end
        if (cnt_r == CNT_W'(SQRT_STEPS)) begin
          cnt_nxt   = '0;
          idx_nxt   = '0;
          state_nxt = ST_DIV;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      ST_DIV: begin
        if (cnt_r == '0) begin
          cmd.div_init = 1'b1;
        end else begin
          cmd.div_step = 1'b1;
        end
        if (cnt_r == CNT_W'(DIV_STEPS)) begin
          state_nxt = ST_DIVW;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      ST_DIVW: begin
        cmd.div_store = 1'b1;
        cnt_nxt       = '0;
        if (idx_r == SLOT_Z) begin
          beat_nxt  = '0;
          state_nxt = ST_OUT;
        end else begin
          idx_nxt   = idx_r + 2'd1;
          state_nxt = ST_DIV;
        end
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (beat_r == LAST_BEAT) begin
            state_nxt = ST_IDLE;
          end else begin
            beat_nxt = beat_r + 2'd1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign last_of_triangle = (beat_r == LAST_BEAT);

  a_no_third_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && in_ready) |-> (phase_r != PHASE_LAST))
    else $error("third vertex accepted while results are pending");

  a_third_starts_work: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && phase_r == PHASE_LAST) |=> (state_r == ST_MUL))
    else $error("third vertex did not start the computation");

  a_three_beats: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && last_of_triangle) |=> !out_valid)
    else $error("result beat after the last of a triangle");

endmodule

>>> rtl/core/ttuv_dp.sv
module ttuv_dp (
  input  logic                                clk,
  input  logic signed [ttuv_pkg::POS_W-1:0]   in_pos_x,
  input  logic signed [ttuv_pkg::POS_W-1:0]   in_pos_y,
  input  logic signed [ttuv_pkg::POS_W-1:0]   in_pos_z,
  input  logic signed [ttuv_pkg::TEX_W-1:0]   in_tex_u,
  input  logic signed [ttuv_pkg::TEX_W-1:0]   in_tex_v,
  input  ttuv_pkg::cmd_t                      cmd,
  output ttuv_pkg::sts_t                      sts,
  output logic signed [ttuv_pkg::TAN_W-1:0]   tangent_x,
  output logic signed [ttuv_pkg::TAN_W-1:0]   tangent_y,
  output logic signed [ttuv_pkg::TAN_W-1:0]   tangent_z,
  output logic                                degenerate
);
  import ttuv_pkg::*;

  logic signed [POS_W-1:0]  hp_r [2][3];
  logic signed [TEX_W-1:0]  hu_r [2];
  logic signed [TEX_W-1:0]  hv_r [2];
  logic signed [POS_W-1:0]  in_pos [3];

  logic signed [EDGE_W-1:0] dp1_r [3];
  logic signed [EDGE_W-1:0] dp2_r [3];
  logic signed [DTEX_W-1:0] du1_r, dv1_r, du2_r, dv2_r;

  logic signed [EDGE_W-1:0] op_a, op_c;
  logic signed [PROD_W-1:0] pa_r, pb_r;
  logic signed [RAW_W-1:0]  diff;
  logic signed [RAW_W-1:0]  t_r [3];
  logic signed [DET_W-1:0]  det_r;

  logic [RAW_W-1:0]  a_r [3];
  logic              neg_r [3];
  logic              degen_r;
  logic [RAW_W-1:0]  m01, m;
  logic [NRM_W-1:0]  a_sel;

  logic [SQ_W-1:0]   sq_r;
  logic [SUM_W-1:0]  sum_r;

  logic [SUM_W-1:0]  s_r;
  logic [ROOT_W-1:0] root_r, bit_r;
  logic [ROOT_W:0]   trial;
  logic              sq_ge;

  logic [RDIV_W-1:0] rden;
  logic [NRM_W+TAN_W-1:0] num;
  logic [RDIV_W-1:0] rem_r;
  logic [TAN_W-1:0]  qn_r;
  logic [RDIV_W:0]   dtrial;
  logic              d_ge;
  logic [TAN_W-1:0]  qsat;
  logic [TAN_W-1:0]  res_r [3];

  assign in_pos[0] = in_pos_x;
  assign in_pos[1] = in_pos_y;
  assign in_pos[2] = in_pos_z;

  always_ff @(posedge clk) begin
    if (cmd.hold_wr) begin
      for (int i = 0; i < 3; i++) begin
        hp_r[cmd.hold_sel][i] <= in_pos[i];
      end
      hu_r[cmd.hold_sel] <= in_tex_u;
      hv_r[cmd.hold_sel] <= in_tex_v;
    end
    if (cmd.capture) begin
      for (int i = 0; i < 3; i++) begin
        dp1_r[i] <= EDGE_W'(hp_r[1][i]) - EDGE_W'(hp_r[0][i]);
        dp2_r[i] <= EDGE_W'(in_pos[i]) - EDGE_W'(hp_r[0][i]);
      end
      du1_r <= DTEX_W'(hu_r[1]) - DTEX_W'(hu_r[0]);
      dv1_r <= DTEX_W'(hv_r[1]) - DTEX_W'(hv_r[0]);
      du2_r <= DTEX_W'(in_tex_u) - DTEX_W'(hu_r[0]);
      dv2_r <= DTEX_W'(in_tex_v) - DTEX_W'(hv_r[0]);
    end
  end

  always_comb begin
    case (cmd.idx)
      2'd0: begin
        op_a = dp1_r[0];
        op_c = dp2_r[0];
      end
      2'd1: begin
        op_a = dp1_r[1];
        op_c = dp2_r[1];
      end
      2'd2: begin
        op_a = dp1_r[2];
        op_c = dp2_r[2];
      end
      default: begin
        op_a = EDGE_W'(du1_r);
        op_c = EDGE_W'(du2_r);
      end
    endcase
  end

  assign diff = RAW_W'(pa_r) - RAW_W'(pb_r);

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      pa_r <= PROD_W'(op_a) * PROD_W'(dv2_r);
      pb_r <= PROD_W'(op_c) * PROD_W'(dv1_r);
    end
    if (cmd.sub) begin
      if (cmd.idx == SLOT_DET) begin
        det_r <= diff[DET_W-1:0];
      end else begin
        t_r[cmd.idx] <= diff;
      end
    end
  end

  assign m01 = (a_r[0] > a_r[1]) ? a_r[0] : a_r[1];
  assign m   = (m01 > a_r[2]) ? m01 : a_r[2];

  assign sts.degen   = degen_r;
  assign sts.norm_ok = m[NRM_W-1] && !(|m[RAW_W-1:NRM_W]);

  always_comb begin
    case (cmd.idx)
      2'd0:    a_sel = a_r[0][NRM_W-1:0];
      2'd1:    a_sel = a_r[1][NRM_W-1:0];
      default: a_sel = a_r[2][NRM_W-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      for (int i = 0; i < 3; i++) begin
        a_r[i]   <= t_r[i][RAW_W-1] ? RAW_W'(-t_r[i]) : RAW_W'(t_r[i]);
        neg_r[i] <= t_r[i][RAW_W-1] ^ det_r[DET_W-1];
        res_r[i] <= '0;
      end
      degen_r <= (det_r == '0) || ((t_r[0] == '0) && (t_r[1] == '0) && (t_r[2] == '0));
      sum_r   <= '0;
    end else if (cmd.norm) begin
      for (int i = 0; i < 3; i++) begin
        if (|m[RAW_W-1:NRM_W+4]) begin
          a_r[i] <= a_r[i] >> 4;
        end else if (|m[RAW_W-1:NRM_W]) begin
          a_r[i] <= a_r[i] >> 1;
        end else if (!(|m[NRM_W-1:NRM_W-5])) begin
          a_r[i] <= a_r[i] << 4;
        end else begin
          a_r[i] <= a_r[i] << 1;
        end
      end
    end else if (cmd.div_store) begin
      res_r[cmd.idx] <= neg_r[cmd.idx] ? TAN_W'(-qsat) : qsat;
    end
    if (cmd.sq) begin
      if (cmd.idx != SLOT_DET) begin
        sq_r <= SQ_W'(a_sel) * SQ_W'(a_sel);
      end
      if (cmd.idx != 2'd0) begin
        sum_r <= sum_r + SUM_W'(sq_r);
      end
    end
  end

  assign trial = {1'b0, root_r} + {1'b0, bit_r};
  assign sq_ge = {{(ROOT_W+1-SUM_W){1'b0}}, s_r} >= trial;

  always_ff @(posedge clk) begin
    if (cmd.sqrt_init) begin
      s_r    <= sum_r;
      root_r <= '0;
      bit_r  <= ROOT_W'(1) << (ROOT_W - 1);
    end else if (cmd.sqrt_step) begin
      if (sq_ge) begin
        s_r    <= s_r - trial[SUM_W-1:0];
        root_r <= (root_r >> 1) + bit_r;
      end else begin
        root_r <= root_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  assign rden   = (root_r[RDIV_W-1:0] == '0) ? RDIV_W'(1) : root_r[RDIV_W-1:0];
  assign num    = {1'b0, a_sel, {(TAN_W-1){1'b0}}} + (NRM_W+TAN_W)'(rden >> 1);
  assign dtrial = {rem_r, qn_r[TAN_W-1]};
  assign d_ge   = dtrial >= {1'b0, rden};
  assign qsat   = qn_r[TAN_W-1] ? {1'b0, {(TAN_W-1){1'b1}}} : qn_r;

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rem_r <= RDIV_W'(num[NRM_W+TAN_W-1:TAN_W]);
      qn_r  <= num[TAN_W-1:0];
    end else if (cmd.div_step) begin
      rem_r <= d_ge ? RDIV_W'(dtrial - {1'b0, rden}) : dtrial[RDIV_W-1:0];
      qn_r  <= {qn_r[TAN_W-2:0], d_ge};
    end
  end

  assign tangent_x  = res_r[0];
  assign tangent_y  = res_r[1];
  assign tangent_z  = res_r[2];
  assign degenerate = degen_r;

endmodule

>>> dv/triangle_tangent_from_uv_checker.sv
module triangle_tangent_from_uv_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic signed [ttuv_pkg::POS_W-1:0]   in_pos_x,
  input  logic signed [ttuv_pkg::POS_W-1:0]   in_pos_y,
  input  logic signed [ttuv_pkg::POS_W-1:0]   in_pos_z,
  input  logic signed [ttuv_pkg::TEX_W-1:0]   in_tex_u,
  input  logic signed [ttuv_pkg::TEX_W-1:0]   in_tex_v,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic signed [ttuv_pkg::TAN_W-1:0]   out_tangent_x,
  input  logic signed [ttuv_pkg::TAN_W-1:0]   out_tangent_y,
  input  logic signed [ttuv_pkg::TAN_W-1:0]   out_tangent_z,
  input  logic                                out_degenerate,
  input  logic                                out_last_of_triangle,
  output int                                  fail_count,
  output int                                  pending_tangents
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [15:0] tx;
    logic [15:0] ty;
    logic [15:0] tz;
    logic        degen;
    logic        last;
  } tangent_beat_t;

  tangent_beat_t exp_mem[16];
  int unsigned wr_cnt, rd_cnt;
  logic signed [63:0] held_pos[2][3];
  logic signed [63:0] held_uv[2][2];
  logic [1:0] phase;

  assign pending_tangents = int'(wr_cnt - rd_cnt);

  function automatic logic [63:0] int_sqrt(logic [63:0] s);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > s) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (s >= res + bitv) begin
        s = s - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  task automatic predict_tangent(logic signed [63:0] p2[3], logic signed [63:0] u2,
                                 logic signed [63:0] v2);
    logic signed [63:0] du1, dv1, du2, dv2, det, t;
    logic [63:0] mag[3], m, s, r, q;
    logic [15:0] res[3];
    logic neg[3], degen;
    int len;
    tangent_beat_t b;
    du1 = held_uv[1][0] - held_uv[0][0];
    dv1 = held_uv[1][1] - held_uv[0][1];
    du2 = u2 - held_uv[0][0];
    dv2 = v2 - held_uv[0][1];
    det = du1 * dv2 - du2 * dv1;
    m = 0;
    for (int i = 0; i < 3; i++) begin
      t = dv2 * (held_pos[1][i] - held_pos[0][i]) - dv1 * (p2[i] - held_pos[0][i]);
      neg[i] = (t < 0) != (det < 0);
      mag[i] = (t < 0) ? -t : t;
      if (mag[i] > m) m = mag[i];
      res[i] = 0;
    end
    degen = (det == 0) || (m == 0);
    if (!degen) begin
      len = 0;
      while (len < 64 && (m >> len) != 0) len++;
      s = 0;
      for (int i = 0; i < 3; i++) begin
        if (len > 30) mag[i] = mag[i] >> (len - 30);
        else mag[i] = mag[i] << (30 - len);
        s = s + mag[i] * mag[i];
      end
      r = int_sqrt(s);
      if (r == 0) r = 1;
      for (int i = 0; i < 3; i++) begin
        q = ((mag[i] << 15) + (r >> 1)) / r;
        if (q > 32767) q = 32767;
        res[i] = neg[i] ? 16'(17'h10000 - q) : q[15:0];
      end
    end
    for (int k = 0; k < 3; k++) begin
      b.tx = res[0];
      b.ty = res[1];
      b.tz = res[2];
      b.degen = degen;
      b.last = (k == 2);
      exp_mem[wr_cnt[3:0]] = b;
      wr_cnt = wr_cnt + 1;
    end
  endtask

  always @(posedge clk) begin
    logic signed [63:0] p2[3];
    tangent_beat_t e, g;
    if (!rst_n) begin
      phase <= '0;
      fail_count <= 0;
      wr_cnt = 0;
      rd_cnt = 0;
    end else begin
      if (out_valid && out_ready) begin
        g = {out_tangent_x, out_tangent_y, out_tangent_z, out_degenerate,
             out_last_of_triangle};
        if (wr_cnt == rd_cnt) begin
          $display("%0t: unexpected beat, actual %h", $time, g);
          fail_count <= fail_count + 1;
        end else begin
          e = exp_mem[rd_cnt[3:0]];
          rd_cnt = rd_cnt + 1;
          if (e !== g) begin
            $display("%0t: mismatch, expected %h actual %h", $time, e, g);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_valid && in_ready) begin
        p2[0] = in_pos_x;
        p2[1] = in_pos_y;
        p2[2] = in_pos_z;
        if (phase < 2'd2) begin
          for (int i = 0; i < 3; i++) held_pos[phase[0]][i] = p2[i];
          held_uv[phase[0]][0] = in_tex_u;
          held_uv[phase[0]][1] = in_tex_v;
          phase <= phase + 2'd1;
        end else begin
          predict_tangent(p2, in_tex_u, in_tex_v);
          phase <= '0;
        end
      end
    end
  end
endmodule

>>> dv/triangle_tangent_from_uv_test.sv
module triangle_tangent_from_uv_test;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready;
  logic signed [31:0] in_pos_x, in_pos_y, in_pos_z;
  logic signed [19:0] in_tex_u, in_tex_v;
  logic signed [15:0] out_tangent_x, out_tangent_y, out_tangent_z;
  logic out_degenerate, out_last_of_triangle;
  int fail_count, pending_tangents;
  logic quiet_sink;

  triangle_tangent_from_uv uut (.*);
  triangle_tangent_from_uv_checker checker_i (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("triangle_tangent_from_uv_test: FAIL");
    $finish;
  end

  function automatic int pick_gap();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  always @(negedge clk) begin
    if (!rst_n || quiet_sink) out_ready <= 1'b1;
    else out_ready <= (pick_gap() == 0);
  end

  task automatic send_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                             logic [19:0] u, logic [19:0] v);
    int gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_pos_x <= x;
    in_pos_y <= y;
    in_pos_z <= z;
    in_tex_u <= u;
    in_tex_v <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [31:0] rand_pos();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(0, 8) - 4;
      3: return 32'($signed($urandom_range(0, 400000)) - 200000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [19:0] rand_uv();
    case ($urandom_range(0, 5))
      0: return 20'h80000;
      1: return 20'h7ffff;
      2: return 20'($urandom_range(0, 6)) - 20'd3;
      default: return 20'($urandom);
    endcase
  endfunction

  initial begin
    logic [31:0] x, y, z;
    logic [19:0] u, v;
    int wait_cycles;
    quiet_sink = 1'b0;
    rst_n = 0;
    in_valid = 0;
    {in_pos_x, in_pos_y, in_pos_z, in_tex_u, in_tex_v} = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // A regular triangle, a zero-area UV triangle and a zero tangent.
    send_vertex(32'd0, 32'd0, 32'd0, 20'd0, 20'd0);
    send_vertex(32'h10000, 32'd0, 32'd0, 20'h10000, 20'd0);
    send_vertex(32'd0, 32'h10000, 32'd0, 20'd0, 20'h10000);
    send_vertex(32'd5, 32'd6, 32'd7, 20'h100, 20'h100);
    send_vertex(32'd8, 32'd9, 32'd1, 20'h200, 20'h200);
    send_vertex(32'd3, 32'd2, 32'd4, 20'h300, 20'h300);
    send_vertex(32'd7, 32'd7, 32'd7, 20'd0, 20'd0);
    send_vertex(32'd7, 32'd7, 32'd7, 20'h10000, 20'd0);
    send_vertex(32'd7, 32'd7, 32'd7, 20'd0, 20'h10000);
    // Extreme coordinates with a negative determinant.
    send_vertex(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 20'h80000, 20'h7ffff);
    send_vertex(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 20'h7ffff, 20'h80000);
    send_vertex(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 20'h80000, 20'h80000);
    send_vertex(32'd0, 32'd0, 32'd0, 20'd0, 20'd0);
    send_vertex(32'd1, 32'd0, 32'd0, 20'd0, 20'd1);
    send_vertex(32'd0, 32'd1, 32'd0, 20'd1, 20'd0);

    for (int i = 0; i < 405; i++) begin
      x = rand_pos();
      y = rand_pos();
      z = rand_pos();
      u = rand_uv();
      v = rand_uv();
      send_vertex(x, y, z, u, v);
    end
    in_valid <= 1'b0;

    wait_cycles = 0;
    while (pending_tangents != 0 && wait_cycles < 200000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (200) @(posedge clk);
    if (fail_count == 0 && pending_tangents == 0) begin
      $display("triangle_tangent_from_uv_test: PASS");
    end else begin
      $display("triangle_tangent_from_uv_test: FAIL");
    end
    $finish;
  end
endmodule
